>>> hw/rtl/utrtf_pkg.sv
// Package for the UTF-8 to RTF token converter.
// Holds the token kinds, the queue entry type, byte constants and the
// UTF-16 split function used by the front end; the queue and back end share the entry type.
package utrtf_pkg;

  // Token kinds as they appear on the result port
  typedef enum logic [1:0] {
    KIND_LITERAL = 2'd0,
    KIND_ESCAPED = 2'd1,
    KIND_LINE    = 2'd2,
    KIND_UNIT    = 2'd3
  } tok_kind_t;

  // Byte classes
  localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
  localparam logic [7:0] BYTE_LBRACE    = 8'h7B;
  localparam logic [7:0] BYTE_RBRACE    = 8'h7D;
  localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  // UTF-16 surrogate constants
  localparam logic [20:0] PLANE1_BASE = 21'h10000;
  localparam logic [15:0] HI_SURR     = 16'hD800;
  localparam logic [15:0] LO_SURR     = 16'hDC00;

  localparam int unsigned POINT_W = 21;
  localparam int unsigned COUNT_W = 32;

  // One request for the back end: zero, one or two tokens plus a count clear
  typedef struct packed {
    tok_kind_t   kind;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        pair;
    logic        clr;
    logic        emit;
  } tok_entry_t;

  typedef struct packed {
    logic        pair;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } utf16_t;

  // Split a code point into one unit or a surrogate pair
  function automatic utf16_t split_point(input logic [POINT_W-1:0] cp);
    logic [POINT_W-1:0] off;
    utf16_t             res;
    off       = cp - PLANE1_BASE;
    res.pair  = (cp[20:16] != 5'd0);
    res.unit0 = res.pair ? (HI_SURR + {5'd0, off[20:10]}) : cp[15:0];
    res.unit1 = LO_SURR + {6'd0, off[9:0]};
    return res;
  endfunction

endpackage

>>> hw/rtl/utrtf_front.sv
// Front end of the UTF-8 to RTF token converter: accepts bytes, tracks the
// open multi-byte sequence and pushes token requests. Depends on utrtf_pkg.
module utrtf_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_text_byte,
  input  logic                   in_end_of_text,
  input  logic                   in_doc_start,
  input  logic                   q_full,
  output logic                   push,
  output utrtf_pkg::tok_entry_t  push_entry
);
  import utrtf_pkg::*;

  logic [POINT_W-1:0] point_r, point_nxt;
  logic [1:0]         left_r, left_nxt;

  logic               take;
  logic               emit_unit;
  logic               emit_byte;
  logic [POINT_W-1:0] point_out;
  logic [1:0]         left_dec;
  tok_kind_t          byte_kind;
  utf16_t             units;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign left_dec = left_r - 2'd1;

  // Classify an ASCII byte
  always_comb begin
    case (in_text_byte) inside
      BYTE_BACKSLASH, BYTE_LBRACE, BYTE_RBRACE: byte_kind = KIND_ESCAPED;
      BYTE_NEWLINE:                             byte_kind = KIND_LINE;
      default:                                  byte_kind = KIND_LITERAL;
    endcase
  end

  // Advance the sequence decoder
  always_comb begin
    point_nxt = point_r;
    left_nxt  = left_r;
    emit_unit = 1'b0;
    emit_byte = 1'b0;
    point_out = point_r;
    if (left_r != 2'd0) begin
      point_nxt = {point_r[POINT_W-7:0], in_text_byte[5:0]};
      point_out = point_nxt;
      if (left_dec == 2'd0 || in_end_of_text) begin
        left_nxt  = 2'd0;
        emit_unit = 1'b1;
      end else begin
        left_nxt = left_dec;
      end
    end else if (!in_text_byte[7]) begin
      emit_byte = 1'b1;
    end else begin
      if ((in_text_byte & LEAD2_MASK) == LEAD2_CODE) begin
        point_nxt = {16'd0, in_text_byte[4:0]};
        left_nxt  = 2'd1;
      end else if ((in_text_byte & LEAD3_MASK) == LEAD3_CODE) begin
        point_nxt = {17'd0, in_text_byte[3:0]};
        left_nxt  = 2'd2;
      end else if ((in_text_byte & LEAD4_MASK) == LEAD4_CODE) begin
        point_nxt = {18'd0, in_text_byte[2:0]};
        left_nxt  = 2'd3;
      end
      point_out = point_nxt;
      // A lead byte at end of text closes at once; stray bytes leave left at zero
      if (left_nxt != 2'd0 && in_end_of_text) begin
        left_nxt  = 2'd0;
        emit_unit = 1'b1;
      end
    end
  end

  assign units = split_point(point_out);

  // Build the request
  always_comb begin
    push_entry.kind  = emit_unit ? KIND_UNIT : byte_kind;
    push_entry.unit0 = emit_unit ? units.unit0 : {8'd0, in_text_byte};
    push_entry.unit1 = units.unit1;
    push_entry.pair  = emit_unit && units.pair;
    push_entry.clr   = in_doc_start;
    push_entry.emit  = emit_unit || emit_byte;
  end

  assign push = take && (emit_unit || emit_byte || in_doc_start);

  // Hold the decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_r <= '0;
      left_r  <= 2'd0;
    end else if (take) begin
      point_r <= point_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

>>> hw/rtl/utrtf_queue.sv
// Short request queue between the front and back ends of the converter.
// Depends on utrtf_pkg for the entry type.
module utrtf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  utrtf_pkg::tok_entry_t  push_entry,
  output logic                   full,
  input  logic                   pop,
  output logic                   head_valid,
  output utrtf_pkg::tok_entry_t  head_entry
);
  import utrtf_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tok_entry_t    slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> hw/rtl/utrtf_back.sv
// Back end of the converter: turns queued requests into tokens, splits
// surrogate pairs, keeps the saturating count and the output register.
// Depends on utrtf_pkg.
module utrtf_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  utrtf_pkg::tok_entry_t  head_entry,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_token_kind,
  output logic signed [15:0]     out_token_value,
  output logic [31:0]            out_chars_so_far,
  output logic                   out_last_of_run
);
  import utrtf_pkg::*;

  logic               half_r, half_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic               vld_r, vld_nxt;
  tok_kind_t          kind_r, kind_nxt;
  logic [15:0]        value_r, value_nxt;
  logic [COUNT_W-1:0] chars_r, chars_nxt;
  logic               last_r, last_nxt;

  logic               load_ok;
  logic [COUNT_W-1:0] base;
  logic [COUNT_W-1:0] inc;

  assign load_ok = !vld_r || out_ready;
  assign base    = (head_entry.clr && !half_r) ? '0 : total_r;
  assign inc     = (base == {COUNT_W{1'b1}}) ? base : base + COUNT_W'(1);

  // Issue tokens and retire requests
  always_comb begin
    half_nxt  = half_r;
    total_nxt = total_r;
    vld_nxt   = vld_r && !out_ready;
    kind_nxt  = kind_r;
    value_nxt = value_r;
    chars_nxt = chars_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (head_valid) begin
      if (!head_entry.emit) begin
        // count clear on a byte that gives no token
        total_nxt = '0;
        pop       = 1'b1;
      end else if (load_ok) begin
        vld_nxt   = 1'b1;
        kind_nxt  = head_entry.kind;
        value_nxt = half_r ? head_entry.unit1 : head_entry.unit0;
        total_nxt = inc;
        chars_nxt = inc;
        if (head_entry.pair && !half_r) begin
          half_nxt = 1'b1;
          last_nxt = 1'b0;
        end else begin
          half_nxt = 1'b0;
          last_nxt = 1'b1;
          pop      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= 1'b0;
      total_r <= '0;
      vld_r   <= 1'b0;
    end else begin
      half_r  <= half_nxt;
      total_r <= total_nxt;
      vld_r   <= vld_nxt;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    chars_r <= chars_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid        = vld_r;
  assign out_token_kind   = kind_r;
  assign out_token_value  = $signed(value_r);
  assign out_chars_so_far = chars_r;
  assign out_last_of_run  = last_r;

endmodule

>>> hw/rtl/utf8_to_rtf_unicode_tokens.sv
// UTF-8 to RTF token converter, top level.
// An accepted byte's request passes through a queue slot, then its first token is registered in the output register.
// Throughput: one byte per cycle while the queue is not full; a surrogate pair is issued as two tokens,
// absorbed by the request queue between front and back ends.
// Reset (rst_n low, synchronous): closes any open sequence, clears the
// character count, empties the queue and drops any pending result.
module utf8_to_rtf_unicode_tokens #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_text_byte,
  input  logic               in_end_of_text,
  input  logic               in_doc_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_token_kind,
  output logic signed [15:0] out_token_value,
  output logic [31:0]        out_chars_so_far,
  output logic               out_last_of_run
);
  import utrtf_pkg::*;

  logic       push, pop, q_full, head_valid;
  tok_entry_t push_entry, head_entry;

  // Decode bytes into requests
  utrtf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .in_doc_start   (in_doc_start),
    .q_full         (q_full),
    .push           (push),
    .push_entry     (push_entry)
  );

  // Buffer requests
  utrtf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // Emit tokens
  utrtf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_entry       (head_entry),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_value  (out_token_value),
    .out_chars_so_far (out_chars_so_far),
    .out_last_of_run  (out_last_of_run)
  );

endmodule
